// ----- rtl/core/csd_pkg.sv -----
// ----------------------------------------------------------------------------
// csd_pkg
// Shared widths, register indexes and types for the current sample smoother.
// ----------------------------------------------------------------------------
package csd_pkg;

    // signed code after sign or zero extension
    localparam int CODE_W     = 17;
    // filtered value, signed Q32.16
    localparam int FILT_W     = 48;
    // shared adder width
    localparam int SUM_W      = 50;
    // shared multiplier operands and product
    localparam int MUL_A_W    = 34;
    localparam int MUL_B_W    = 18;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    // filter weight, Q1.16
    localparam int ALPHA_W    = 17;
    localparam int ALPHA_FRAC = 16;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h1_0000;

    localparam logic [31:0] INT32_MAX_C = 32'h7FFF_FFFF;
    localparam logic [31:0] INT32_MIN_C = 32'h8000_0000;

    // configuration register indexes
    localparam int CFG_ADDR_W = 3;
    typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;
    localparam cfg_addr_t CFG_SENSOR_MODE  = 3'd0;
    localparam cfg_addr_t CFG_WINDOW_LOW   = 3'd1;
    localparam cfg_addr_t CFG_WINDOW_HIGH  = 3'd2;
    localparam cfg_addr_t CFG_SCALE        = 3'd3;
    localparam cfg_addr_t CFG_OFFSET       = 3'd4;
    localparam cfg_addr_t CFG_ALPHA        = 3'd5;
    localparam cfg_addr_t CFG_NOLOAD_ENTER = 3'd6;
    localparam cfg_addr_t CFG_NOLOAD_EXIT  = 3'd7;

    // request to the shared multiplier
    typedef struct packed {
        logic                      en;
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
    } mul_req_t;

endpackage

// ----- rtl/core/current_sample_smoother_deadband.sv -----
// ----------------------------------------------------------------------------
// current_sample_smoother_deadband
// Converts current samples to mA, smooths them and applies a no-load deadband.
// ----------------------------------------------------------------------------
// One sample beat at a time is taken while s_ready is high. A rejected beat
// (read failed, or an analog code outside the window) clears the filter; its
// result goes straight to ST_DONE and from there into the output register.
// An accepted sample runs through one shared multiplier and one shared
// 50-bit adder under a small sequencer: the first sample after a clear steps
// through MUL_X, ADD_X, ABS and LATCH, later ones through MUL_X, ADD_X, DIFF,
// MUL_H, MUL_L, ADD_L, ABS and LATCH; ROUND and NEG follow unless the result
// lands in the no-load deadband. ST_DONE holds until the output register is
// free, so while it is full and m_ready is low no new sample is taken. The
// output register lets a result wait while the next sample is taken.
// ----------------------------------------------------------------------------
module current_sample_smoother_deadband #(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // sample channel
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [15:0]               s_sample_code,
    input  logic                      s_read_ok,
    // result channel
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [31:0]        m_reading_ma,
    output logic                      m_reading_ok,
    output logic                      m_no_load,
    // configuration write channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  csd_pkg::cfg_addr_t        cfg_addr,
    input  logic [31:0]               cfg_data
);
    import csd_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MUL_X = 4'd1;
    localparam logic [3:0] ST_ADD_X = 4'd2;
    localparam logic [3:0] ST_DIFF  = 4'd3;
    localparam logic [3:0] ST_MUL_H = 4'd4;
    localparam logic [3:0] ST_MUL_L = 4'd5;
    localparam logic [3:0] ST_ADD_L = 4'd6;
    localparam logic [3:0] ST_ABS   = 4'd7;
    localparam logic [3:0] ST_LATCH = 4'd8;
    localparam logic [3:0] ST_ROUND = 4'd9;
    localparam logic [3:0] ST_NEG   = 4'd10;
    localparam logic [3:0] ST_DONE  = 4'd11;

    // configuration registers
    logic                 sensor_mode_reg;
    logic [15:0]          window_low_reg;
    logic [15:0]          window_high_reg;
    logic [31:0]          scale_reg;
    logic [31:0]          offset_reg;
    logic [ALPHA_W-1:0]   alpha_reg;
    logic [23:0]          enter_reg;
    logic [23:0]          exit_reg;

    // sequencer and filter state
    logic [3:0]           state_reg, state_next;
    logic                 primed_reg, primed_next;
    logic                 latch_reg, latch_next;
    logic [FILT_W-1:0]    f_reg, f_next;
    logic [FILT_W-1:0]    x_reg, x_next;
    logic [SUM_W-1:0]     acc_reg, acc_next;
    logic [FILT_W-1:0]    mag_reg, mag_next;
    logic [CODE_W-1:0]    code_reg, code_next;
    logic [31:0]          res_ma_reg, res_ma_next;
    logic                 res_valid_reg, res_valid_next;

    // output register
    logic                 m_valid_reg;
    logic [31:0]          m_reading_ma_reg;
    logic                 m_reading_ok_reg;
    logic                 m_no_load_reg;

    // shared units
    mul_req_t             mul_req;
    logic signed [PROD_W-1:0] prod;
    logic [PROD_W-1:0]    prod_shift;
    logic [SUM_W-1:0]     add_a, add_b, sum;
    logic                 add_cin;

    // decoded sample
    logic [SAMPLE_BITS-1:0] raw;
    logic [CODE_W-1:0]    code_ext;
    logic                 in_window;
    logic                 sample_ok;
    logic                 s_beat;
    logic                 out_free;

    // derived values
    logic [ALPHA_W-1:0]   alpha_eff;
    logic                 f_neg;
    logic                 sum_ovf;
    logic [FILT_W-1:0]    sum_sat;
    logic [FILT_W-1:0]    enter_fx, exit_fx;
    logic [SUM_W-1:0]     r_wide;
    logic [SUM_W-1:0]     half_lsb;

    csd_mul u_mul (
        .aclk (aclk),
        .req  (mul_req),
        .prod (prod)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign s_beat    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    // decode the incoming code: zero extend in analog mode, sign extend in digital
    assign raw       = s_sample_code[SAMPLE_BITS-1:0];
    assign code_ext  = sensor_mode_reg
                     ? {{(CODE_W-SAMPLE_BITS){raw[SAMPLE_BITS-1]}}, raw}
                     : {{(CODE_W-SAMPLE_BITS){1'b0}}, raw};
    assign in_window = (16'(raw) >= window_low_reg) && (16'(raw) <= window_high_reg);
    assign sample_ok = s_read_ok && (sensor_mode_reg || in_window);

    assign alpha_eff = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
    assign f_neg     = f_reg[FILT_W-1];
    assign enter_fx  = FILT_W'(enter_reg) << FRAC_BITS;
    assign exit_fx   = FILT_W'(exit_reg) << FRAC_BITS;
    assign r_wide    = acc_reg >> FRAC_BITS;
    assign half_lsb  = SUM_W'(1) << (FRAC_BITS - 1);
    assign prod_shift = PROD_W'(prod >>> ALPHA_FRAC);

    // saturate the adder result to the filter width
    assign sum_ovf = !((sum[SUM_W-1] == sum[FILT_W-1]) && (sum[SUM_W-2] == sum[FILT_W-1]));
    assign sum_sat = sum[SUM_W-1] ? {1'b1, {(FILT_W-1){1'b0}}} : {1'b0, {(FILT_W-1){1'b1}}};

    // steer the shared multiplier
    always_comb begin
        mul_req.en = 1'b0;
        mul_req.a  = '0;
        mul_req.b  = '0;
        case (state_reg)
            ST_MUL_X: begin
                mul_req.en = 1'b1;
                mul_req.a  = MUL_A_W'($signed(scale_reg));
                mul_req.b  = MUL_B_W'($signed(code_reg));
            end
            ST_MUL_H: begin
                mul_req.en = 1'b1;
                mul_req.a  = MUL_A_W'($signed(acc_reg[FILT_W:ALPHA_FRAC]));
                mul_req.b  = {1'b0, alpha_eff};
            end
            ST_MUL_L: begin
                mul_req.en = 1'b1;
                mul_req.a  = {{(MUL_A_W-ALPHA_FRAC){1'b0}}, acc_reg[ALPHA_FRAC-1:0]};
                mul_req.b  = {1'b0, alpha_eff};
            end
            default: begin
                mul_req.en = 1'b0;
            end
        endcase
    end

    // steer the shared adder
    always_comb begin
        add_a   = '0;
        add_b   = '0;
        add_cin = 1'b0;
        case (state_reg)
            ST_ADD_X: begin
                add_a = prod[SUM_W-1:0];
                add_b = SUM_W'($signed(offset_reg));
            end
            ST_DIFF: begin
                add_a   = SUM_W'($signed(x_reg));
                add_b   = ~SUM_W'($signed(f_reg));
                add_cin = 1'b1;
            end
            ST_MUL_L: begin
                add_a = SUM_W'($signed(f_reg));
                add_b = prod[SUM_W-1:0];
            end
            ST_ADD_L: begin
                add_a = acc_reg;
                add_b = prod_shift[SUM_W-1:0];
            end
            ST_ABS: begin
                add_b   = f_neg ? ~SUM_W'($signed(f_reg)) : SUM_W'($signed(f_reg));
                add_cin = f_neg;
            end
            ST_ROUND: begin
                add_a = {{(SUM_W-FILT_W){1'b0}}, mag_reg};
                add_b = half_lsb;
            end
            ST_NEG: begin
                add_b   = ~r_wide;
                add_cin = 1'b1;
            end
            default: begin
                add_cin = 1'b0;
            end
        endcase
    end

    assign sum = add_a + add_b + SUM_W'(add_cin);

    // sequencer
    always_comb begin
        state_next     = state_reg;
        primed_next    = primed_reg;
        latch_next     = latch_reg;
        f_next         = f_reg;
        x_next         = x_reg;
        acc_next       = acc_reg;
        mag_next       = mag_reg;
        code_next      = code_reg;
        res_ma_next    = res_ma_reg;
        res_valid_next = res_valid_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_beat) begin
                    code_next = code_ext;
                    if (sample_ok) begin
                        state_next = ST_MUL_X;
                    end else begin
                        // drop the sample and clear the filter
                        primed_next    = 1'b0;
                        f_next         = '0;
                        latch_next     = 1'b1;
                        res_ma_next    = '0;
                        res_valid_next = 1'b0;
                        state_next     = ST_DONE;
                    end
                end
            end
            ST_MUL_X: begin
                state_next = ST_ADD_X;
            end
            ST_ADD_X: begin
                // converted sample, saturated to the filter range
                x_next = sum_ovf ? sum_sat : sum[FILT_W-1:0];
                if (!primed_reg) begin
                    f_next      = sum_ovf ? sum_sat : sum[FILT_W-1:0];
                    primed_next = 1'b1;
                    state_next  = ST_ABS;
                end else begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF: begin
                acc_next   = sum;
                state_next = ST_MUL_H;
            end
            ST_MUL_H: begin
                state_next = ST_MUL_L;
            end
            ST_MUL_L: begin
                // add the high partial step
                acc_next   = sum;
                state_next = ST_ADD_L;
            end
            ST_ADD_L: begin
                // add the floored low partial step
                f_next     = sum[FILT_W-1:0];
                state_next = ST_ABS;
            end
            ST_ABS: begin
                mag_next   = sum[FILT_W-1:0];
                state_next = ST_LATCH;
            end
            ST_LATCH: begin
                // hysteresis: leave on strict greater, return on strict less
                if (latch_reg) begin
                    latch_next = !(mag_reg > enter_fx);
                end else begin
                    latch_next = (mag_reg < exit_fx);
                end
                res_valid_next = 1'b1;
                res_ma_next    = '0;
                if ((latch_reg && !(mag_reg > enter_fx)) || (!latch_reg && (mag_reg < exit_fx))) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                acc_next   = sum;
                state_next = ST_NEG;
            end
            ST_NEG: begin
                // apply sign and saturate to int32
                if (!f_neg) begin
                    res_ma_next = (r_wide > SUM_W'(INT32_MAX_C)) ? INT32_MAX_C : r_wide[31:0];
                end else begin
                    res_ma_next = (r_wide >= SUM_W'(INT32_MIN_C)) ? INT32_MIN_C : sum[31:0];
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            primed_reg  <= 1'b0;
            latch_reg   <= 1'b1;
            f_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            primed_reg <= primed_next;
            latch_reg  <= latch_next;
            f_reg      <= f_next;
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath and output payload
    always_ff @(posedge aclk) begin
        x_reg         <= x_next;
        acc_reg       <= acc_next;
        mag_reg       <= mag_next;
        code_reg      <= code_next;
        res_ma_reg    <= res_ma_next;
        res_valid_reg <= res_valid_next;
        if (state_reg == ST_DONE && out_free) begin
            m_reading_ma_reg <= res_ma_reg;
            m_reading_ok_reg <= res_valid_reg;
            m_no_load_reg    <= latch_reg;
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sensor_mode_reg <= 1'b0;
            window_low_reg  <= 16'h0000;
            window_high_reg <= 16'hFFFF;
            scale_reg       <= 32'h0001_0000;
            offset_reg      <= 32'h0000_0000;
            alpha_reg       <= ALPHA_ONE;
            enter_reg       <= 24'h00_0000;
            exit_reg        <= 24'h00_0000;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_addr)
                CFG_SENSOR_MODE:  sensor_mode_reg <= cfg_data[0];
                CFG_WINDOW_LOW:   window_low_reg  <= cfg_data[15:0];
                CFG_WINDOW_HIGH:  window_high_reg <= cfg_data[15:0];
                CFG_SCALE:        scale_reg       <= cfg_data;
                CFG_OFFSET:       offset_reg      <= cfg_data;
                CFG_ALPHA:        alpha_reg       <= cfg_data[ALPHA_W-1:0];
                CFG_NOLOAD_ENTER: enter_reg       <= cfg_data[23:0];
                CFG_NOLOAD_EXIT:  exit_reg        <= cfg_data[23:0];
                default:          sensor_mode_reg <= sensor_mode_reg;
            endcase
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_reading_ma = m_reading_ma_reg;
    assign m_reading_ok = m_reading_ok_reg;
    assign m_no_load    = m_no_load_reg;

endmodule

// ----- rtl/core/csd_mul.sv -----
// ----------------------------------------------------------------------------
// csd_mul
// Shared signed multiplier with a registered product, one request a cycle.
// ----------------------------------------------------------------------------
module csd_mul (
    input  logic                              aclk,
    input  csd_pkg::mul_req_t                 req,
    output logic signed [csd_pkg::PROD_W-1:0] prod
);
    import csd_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    // capture the product when a request is issued, hold otherwise
    always_ff @(posedge aclk) begin
        if (req.en) begin
            prod_reg <= PROD_W'(req.a * req.b);
        end
    end

    assign prod = prod_reg;

endmodule

// ----- rtl/core/csd_checker.sv -----
// ----------------------------------------------------------------------------
// csd_checker
// Port-level checks for the current sample smoother, bound to the top level.
// ----------------------------------------------------------------------------
module csd_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [31:0] m_reading_ma,
    input logic               m_reading_ok,
    input logic               m_no_load
);

    // a rejected sample reports zero current and the no-load state
    a_reject_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_reading_ok |-> m_no_load && (m_reading_ma == 32'sd0))
        else $error("rejected result is not cleared");

    // the deadband forces the current to zero
    a_deadband_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_no_load |-> (m_reading_ma == 32'sd0))
        else $error("nonzero current while in no-load state");

    // one sample at a time: ready drops after each accepted beat
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("sample taken while the previous one is in flight");

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_reading_ma))
        else $error("stalled result changed");

endmodule

bind current_sample_smoother_deadband csd_checker u_csd_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_reading_ma (m_reading_ma),
    .m_reading_ok (m_reading_ok),
    .m_no_load    (m_no_load)
);
